// ===== sv/note_tone_synthesizer_core_defines.svh =====
// Assertion macros for the note tone synthesizer.
// Used by the top level only; ASSERT_OFF removes all checks.
`ifndef NOTE_TONE_SYNTHESIZER_CORE_DEFINES_SVH
`define NOTE_TONE_SYNTHESIZER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define NTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");
`define NTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define NTS_ASSERT_IMPL(lbl, ante, cons)
`define NTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/nts_pkg.sv =====
// Shared types, constants and pitch tables of the note tone synthesizer.
// No dependencies; used by the controller, the datapath and the top level.
package nts_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SAMPLE_RATE = 3'd0;
  localparam logic [2:0] CFG_TEMPO       = 3'd1;
  localparam logic [2:0] CFG_KEY_LETTER  = 3'd2;
  localparam logic [2:0] CFG_KEY_DEGREE  = 3'd3;
  localparam logic [2:0] CFG_MAX_AMP     = 3'd4;

  // Divisor width: sample rate shifted left by up to five places.
  localparam int DIV_DW = 23;

  // Polynomial constants of the quarter-wave sine, Q30.
  localparam logic [30:0] HORN_INIT = 31'd172271;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PREP1,
    OP_PREP2,
    OP_DIVC,
    OP_CNTWB,
    OP_REST,
    OP_FREQ,
    OP_DIVS,
    OP_STEPWB,
    OP_SINX,
    OP_SQR,
    OP_HORN,
    OP_SFIN,
    OP_AMP,
    OP_EMIT,
    OP_EMIT_REST
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] horn_sel;
    logic       capture;
  } nts_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic is_rest;
    logic cnt_zero;
    logic resting;
    logic out_full;
  } nts_stat_t;

  // Key letter frequency in Q16 Hz; code seven is G.
  function automatic logic [24:0] letter_q16(input logic [2:0] code);
    logic [24:0] v;
    case (code)
      3'd0:    v = 25'd28835840;
      3'd1:    v = 25'd32366920;
      3'd2:    v = 25'd17146184;
      3'd3:    v = 25'd19245302;
      3'd4:    v = 25'd21602632;
      3'd5:    v = 25'd22887137;
      default: v = 25'd25690112;
    endcase
    return v;
  endfunction

  // Semitone ratio 2^(k/12) in Q16.
  function automatic logic [16:0] semi_q16(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd69433;
      4'd2:    v = 17'd73562;
      4'd3:    v = 17'd77936;
      4'd4:    v = 17'd82570;
      4'd5:    v = 17'd87480;
      4'd6:    v = 17'd92682;
      4'd7:    v = 17'd98193;
      4'd8:    v = 17'd104032;
      4'd9:    v = 17'd110218;
      4'd10:   v = 17'd116772;
      default: v = 17'd123715;
    endcase
    return v;
  endfunction

  // Semitones above the tonic of each major scale degree; degree zero as one.
  function automatic logic [3:0] degree_semis(input logic [2:0] d);
    logic [3:0] v;
    case (d)
      3'd2:    v = 4'd2;
      3'd3:    v = 4'd4;
      3'd4:    v = 4'd5;
      3'd5:    v = 4'd7;
      3'd6:    v = 4'd9;
      3'd7:    v = 4'd11;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // Horner step constants, Q30.
  function automatic logic [30:0] horn_const(input logic [1:0] sel);
    logic [30:0] v;
    case (sel)
      2'd0:    v = 31'd5026995;
      2'd1:    v = 31'd85569306;
      2'd2:    v = 31'd693598672;
      default: v = 31'd1686629714;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/nts_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No package dependencies; instantiated by the datapath.
module nts_div #(
  parameter int NW = 45,
  parameter int DW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] dsr_q, dsr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DW:0]   rem_sh;

  // One shift and trial subtract per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sh - {1'b0, dsr_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/nts_dp.sv =====
// Datapath: configuration registers, note state, shared multiplier,
// divider, sine polynomial and output register. Uses nts_pkg and nts_div.
module nts_dp import nts_pkg::*; #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [17:0]            cfg_wdata_i,
  input  logic [2:0]             note_degree_i,
  input  logic signed [2:0]      octave_shift_i,
  input  logic [7:0]             length_num_i,
  input  logic [7:0]             length_den_i,
  input  nts_cmd_t               cmd_i,
  output nts_stat_t              stat_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   last_o
);

  localparam int LOG_DEPTH = $clog2(SINE_TABLE_DEPTH);
  localparam int NW        = (PHASE_BITS + 13 > 32) ? PHASE_BITS + 13 : 32;
  localparam int EBASE     = PHASE_BITS - 16;
  localparam logic signed [25:0] S_HI = 26'sd2 ** (SAMPLE_BITS - 1) - 26'sd1;
  localparam logic signed [25:0] S_LO = -(26'sd2 ** (SAMPLE_BITS - 1));

  // Configuration registers.
  logic [17:0] rate_q;
  logic [9:0]  tempo_q;
  logic [2:0]  key_letter_q;
  logic [2:0]  key_degree_q;
  logic [14:0] max_amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= 18'd44100;
      tempo_q      <= 10'd120;
      key_letter_q <= 3'd2;
      key_degree_q <= 3'd1;
      max_amp_q    <= 15'd32767;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_RATE: rate_q       <= cfg_wdata_i;
        CFG_TEMPO:       tempo_q      <= cfg_wdata_i[9:0];
        CFG_KEY_LETTER:  key_letter_q <= cfg_wdata_i[2:0];
        CFG_KEY_DEGREE:  key_degree_q <= cfg_wdata_i[2:0];
        CFG_MAX_AMP:     max_amp_q    <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Captured note fields.
  logic [2:0]        deg_q;
  logic signed [2:0] oct_in_q;
  logic [7:0]        num_q, den_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      deg_q    <= note_degree_i;
      oct_in_q <= octave_shift_i;
      num_q    <= length_num_i;
      den_q    <= length_den_i;
    end
  end

  // Zero divisors count as one.
  logic [17:0] rate_nz;
  logic [9:0]  tempo_nz;
  logic [7:0]  den_nz;
  logic [13:0] num60;
  assign rate_nz  = (rate_q == '0) ? 18'd1 : rate_q;
  assign tempo_nz = (tempo_q == '0) ? 10'd1 : tempo_q;
  assign den_nz   = (den_q == '0) ? 8'd1 : den_q;
  assign num60    = {num_q, 6'b0} - {4'b0, num_q, 2'b0};

  // Semitone distance, folded into one octave.
  logic signed [4:0] k_raw;
  assign k_raw = $signed({1'b0, degree_semis(deg_q)})
               - $signed({1'b0, degree_semis(key_degree_q)});

  // Working registers.
  logic [31:0]       dividend_q;
  logic [17:0]       divisor_q;
  logic [3:0]        semi_idx_q;
  logic signed [3:0] oct_q;
  logic [25:0]       f_q;
  logic [30:0]       x_q, x2_q, r_q;
  logic [1:0]        quad_q;
  logic [14:0]       mag_q, m_q;

  // Note state registers.
  logic [PHASE_BITS-1:0] phase_q, step_q;
  logic [31:0]           cnt_q;
  logic                  resting_q;
  logic                  emit;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_PREP1: begin mul_a = 32'(rate_q);               mul_b = 32'(num60);       end
      OP_PREP2: begin mul_a = 32'(den_nz);               mul_b = 32'(tempo_nz);    end
      OP_FREQ:  begin mul_a = 32'(letter_q16(key_letter_q));
                      mul_b = 32'(semi_q16(semi_idx_q)); end
      OP_SQR:   begin mul_a = 32'(x_q);                  mul_b = 32'(x_q);         end
      OP_HORN:  begin mul_a = 32'(x2_q);                 mul_b = 32'(r_q);         end
      OP_SFIN:  begin mul_a = 32'(x_q);                  mul_b = 32'(r_q);         end
      OP_AMP:   begin mul_a = 32'(mag_q);                mul_b = 32'(max_amp_q);   end
      default: ;
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // Divider operands: sample count or phase step.
  logic signed [7:0] e_w;
  logic [7:0]        e_neg;
  logic [NW-1:0]     div_n;
  logic [DIV_DW-1:0] div_d;
  logic              div_start;
  logic              div_busy;
  logic [NW-1:0]     quot;

  assign e_w   = 8'(EBASE) + {{4{oct_q[3]}}, oct_q};
  assign e_neg = -e_w;

  always_comb begin
    div_n = NW'(dividend_q);
    div_d = DIV_DW'(divisor_q);
    if (cmd_i.op == OP_DIVS) begin
      if (!e_w[7]) begin
        div_n = NW'(f_q) << e_w[5:0];
        div_d = DIV_DW'(rate_nz);
      end else begin
        div_n = NW'(f_q);
        div_d = DIV_DW'(rate_nz) << e_neg[2:0];
      end
    end
  end
  assign div_start = (cmd_i.op == OP_DIVC) || (cmd_i.op == OP_DIVS);

  nts_div #(
    .NW(NW),
    .DW(DIV_DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_n),
    .divisor_i (div_d),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  // Phase to quadrant and quarter-wave argument.
  logic [LOG_DEPTH-1:0] idx;
  logic [29:0]          x_raw;
  assign idx   = phase_q[PHASE_BITS-1 -: LOG_DEPTH];
  assign x_raw = {idx[LOG_DEPTH-3:0], {(32 - LOG_DEPTH){1'b0}}};

  // Rounded and held sine magnitude.
  logic [31:0] s_round;
  logic [16:0] s_q15;
  assign s_round = {1'b0, prod[60:30]} + 32'd16384;
  assign s_q15   = s_round[31:15];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_PREP1: begin
        dividend_q <= prod[31:0];
        if (k_raw < 0) begin
          semi_idx_q <= 4'(k_raw + 5'sd12);
          oct_q      <= {oct_in_q[2], oct_in_q} - 4'sd1;
        end else begin
          semi_idx_q <= k_raw[3:0];
          oct_q      <= {oct_in_q[2], oct_in_q};
        end
      end
      OP_PREP2: divisor_q <= prod[17:0];
      OP_FREQ:  f_q <= prod[41:16];
      OP_SINX: begin
        quad_q <= idx[LOG_DEPTH-1 -: 2];
        x_q    <= idx[LOG_DEPTH-2] ? (31'h4000_0000 - {1'b0, x_raw}) : {1'b0, x_raw};
      end
      OP_SQR: begin
        x2_q <= prod[60:30];
        r_q  <= HORN_INIT;
      end
      OP_HORN: r_q <= horn_const(cmd_i.horn_sel) - prod[60:30];
      OP_SFIN: mag_q <= (s_q15 > 17'd32767) ? 15'd32767 : s_q15[14:0];
      OP_AMP:  m_q <= prod[29:15];
      default: ;
    endcase
  end

  // Note state.
  assign emit = (cmd_i.op == OP_EMIT) || (cmd_i.op == OP_EMIT_REST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
      resting_q <= 1'b1;
    end else begin
      case (cmd_i.op)
        OP_CNTWB: cnt_q <= quot[31:0];
        OP_REST: begin
          resting_q <= 1'b1;
          phase_q   <= '0;
          step_q    <= '0;
        end
        OP_STEPWB: begin
          step_q    <= quot[PHASE_BITS-1:0];
          resting_q <= 1'b0;
        end
        OP_EMIT: begin
          phase_q <= phase_q + step_q;
          cnt_q   <= cnt_q - 32'd1;
        end
        OP_EMIT_REST: cnt_q <= cnt_q - 32'd1;
        default: ;
      endcase
    end
  end

  // Signed sample with hold to the output range.
  logic signed [25:0] smp_raw, smp;
  always_comb begin
    smp_raw = quad_q[1] ? -$signed({11'b0, m_q}) : $signed({11'b0, m_q});
    smp = smp_raw;
    if (smp_raw > S_HI) smp = S_HI;
    if (smp_raw < S_LO) smp = S_LO;
  end

  // Output register; it frees when the receiver takes the transfer.
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sample_q <= (cmd_i.op == OP_EMIT) ? SAMPLE_BITS'(smp) : '0;
      last_q   <= (cnt_q == 32'd1);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign last_o          = last_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.is_rest  = (deg_q == '0);
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.resting  = resting_q;
  assign stat_o.out_full = out_valid_q && !out_ready_i;

endmodule

// ===== sv/nts_ctrl.sv =====
// Controller: sequences note loads and sample ticks over the datapath.
// Uses nts_pkg for the command and status structs.
module nts_ctrl import nts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_mode_i,
  output logic      in_ready_o,
  input  nts_stat_t stat_i,
  output nts_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_DIVC, ST_WAITC, ST_CNTWB, ST_REST,
    ST_FREQ, ST_DIVS, ST_WAITS, ST_STEPWB, ST_CHECK, ST_EREST, ST_SINX,
    ST_SQR, ST_HORN, ST_SFIN, ST_AMP, ST_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] horn_q;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and Horner step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      horn_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE:   if (accept) state_q <= in_mode_i ? ST_CHECK : ST_PREP1;
        ST_PREP1:  state_q <= ST_PREP2;
        ST_PREP2:  state_q <= ST_DIVC;
        ST_DIVC:   state_q <= ST_WAITC;
        ST_WAITC:  if (!stat_i.div_busy) state_q <= ST_CNTWB;
        ST_CNTWB:  state_q <= stat_i.is_rest ? ST_REST : ST_FREQ;
        ST_REST:   state_q <= ST_IDLE;
        ST_FREQ:   state_q <= ST_DIVS;
        ST_DIVS:   state_q <= ST_WAITS;
        ST_WAITS:  if (!stat_i.div_busy) state_q <= ST_STEPWB;
        ST_STEPWB: state_q <= ST_IDLE;
        ST_CHECK: begin
          if (stat_i.cnt_zero) state_q <= ST_IDLE;
          else if (stat_i.resting) state_q <= ST_EREST;
          else state_q <= ST_SINX;
        end
        ST_EREST:  if (!stat_i.out_full) state_q <= ST_IDLE;
        ST_SINX:   state_q <= ST_SQR;
        ST_SQR: begin
          horn_q  <= '0;
          state_q <= ST_HORN;
        end
        ST_HORN: begin
          horn_q <= horn_q + 2'd1;
          if (horn_q == 2'd3) state_q <= ST_SFIN;
        end
        ST_SFIN:   state_q <= ST_AMP;
        ST_AMP:    state_q <= ST_EMIT;
        ST_EMIT:   if (!stat_i.out_full) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd_o.capture  = accept;
    cmd_o.horn_sel = horn_q;
    case (state_q)
      ST_PREP1:  cmd_o.op = OP_PREP1;
      ST_PREP2:  cmd_o.op = OP_PREP2;
      ST_DIVC:   cmd_o.op = OP_DIVC;
      ST_CNTWB:  cmd_o.op = OP_CNTWB;
      ST_REST:   cmd_o.op = OP_REST;
      ST_FREQ:   cmd_o.op = OP_FREQ;
      ST_DIVS:   cmd_o.op = OP_DIVS;
      ST_STEPWB: cmd_o.op = OP_STEPWB;
      ST_SINX:   cmd_o.op = OP_SINX;
      ST_SQR:    cmd_o.op = OP_SQR;
      ST_HORN:   cmd_o.op = OP_HORN;
      ST_SFIN:   cmd_o.op = OP_SFIN;
      ST_AMP:    cmd_o.op = OP_AMP;
      ST_EREST:  cmd_o.op = stat_i.out_full ? OP_NONE : OP_EMIT_REST;
      ST_EMIT:   cmd_o.op = stat_i.out_full ? OP_NONE : OP_EMIT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== sv/note_tone_synthesizer_core.sv =====
// Note tone synthesizer: note events in, sine samples out.
// Input stream: tuser is the mode (0 loads a note, 1 is a sample tick).
// A load sets the sample count, floor(60*rate*num/(den*tempo)), and the
// phase step of the note's pitch; a rest (degree zero) clears the phase.
// A tick of a sounding note gives one sample, trunc(sin(phase)*max_amp),
// with tlast on the note's final sample; a tick after the note ends gives
// no transfer. A sounding load runs two divisions of NW = max(PHASE_BITS+13,
// 32) bits and a rest load one; the divisions give one bit per cycle and set
// the load time. A sounding tick's time is set by the Horner steps on the
// shared multiplier; a rest tick and a tick after the note ends skip them.
// One item is in work at a time; the next is taken once it finishes.
// The output register holds a finished sample while the receiver stalls;
// an item can be taken meanwhile, and the next sample waits for it.
// Reset restores the default registers (44100, 120, C, degree 1, 32767),
// a zero phase and a resting, empty note. Configuration must be written while
// the block is idle, which it does not enforce; there is no read-back.
// Depends on nts_pkg, nts_ctrl, nts_dp and the defines header.
`include "note_tone_synthesizer_core_defines.svh"
module note_tone_synthesizer_core import nts_pkg::*; #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // note_degree[2:0], octave_shift[5:3], length_num[13:6], length_den[21:14]
  input  logic [23:0] s_axis_tdata,
  // mode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sample[SAMPLE_BITS-1:0]
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  nts_cmd_t               cmd;
  nts_stat_t              stat;
  logic [SAMPLE_BITS-1:0] sample;

  nts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_mode_i (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  nts_dp #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .note_degree_i (s_axis_tdata[2:0]),
    .octave_shift_i($signed(s_axis_tdata[5:3])),
    .length_num_i  (s_axis_tdata[13:6]),
    .length_den_i  (s_axis_tdata[21:14]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .sample_o      (sample),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'(sample);

  // A division is never restarted while one runs.
  `NTS_ASSERT_IMPL(a_div_start_idle, (cmd.op == OP_DIVC) || (cmd.op == OP_DIVS), !stat.div_busy)
  // No sample overwrites one that the receiver has not taken.
  `NTS_ASSERT_IMPL(a_no_overwrite, (cmd.op == OP_EMIT) || (cmd.op == OP_EMIT_REST),
                   !(m_axis_tvalid && !m_axis_tready))
  // No item is taken while a division is in progress.
  `NTS_ASSERT_IMPL(a_busy_not_ready, stat.div_busy, !s_axis_tready)
  // An emitted sample shows as valid on the next cycle.
  `NTS_ASSERT_NEXT(a_emit_valid, (cmd.op == OP_EMIT) || (cmd.op == OP_EMIT_REST), m_axis_tvalid)

endmodule

// ===== verif/tb.sv =====
// Testbench for note_tone_synthesizer_core: streams note loads and sample ticks,
// predicts every sample with a bit-accurate model of the tone math.
// Depends on nts_pkg and the core RTL.
module tb;
  import nts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = 32;
  localparam int TBL = 256;
  localparam longint PMASK = (64'd1 << PB) - 1;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } smp_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [17:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  note_tone_synthesizer_core DUT (.*);

  // Predictor state and shadow registers.
  longint unsigned rate_r, tempo_r, letter_r, keydeg_r, amp_r;
  longint unsigned phase_acc, step_acc, left_cnt;
  bit              rest_flag;
  smp_t            sample_q[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_samples = 0;
  int  cycles = 0;
  bit  hold_rx = 0;
  int  gap_max = 3;

  initial forever #6 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint unsigned letter_hz(input longint unsigned c);
    case (c)
      0: return 28835840;
      1: return 32366920;
      2: return 17146184;
      3: return 19245302;
      4: return 21602632;
      5: return 22887137;
      default: return 25690112;
    endcase
  endfunction

  function automatic longint unsigned semi_ratio(input int k);
    longint unsigned t[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                               92682, 98193, 104032, 110218, 116772, 123715};
    return t[k];
  endfunction

  function automatic int scale_semis(input longint unsigned d);
    int t[8] = '{0, 0, 2, 4, 5, 7, 9, 11};
    return t[d & 7];
  endfunction

  // Quarter-wave Horner sine in Q1.15, signed by the half turn.
  function automatic int sine_q15(input longint unsigned ph);
    longint unsigned idx, t, x, x2, r, s;
    int quad;
    idx = ((ph & PMASK) * TBL) >> PB;
    t = (idx << 32) / TBL;
    quad = int'((t >> 30) & 3);
    x = t & ((64'd1 << 30) - 1);
    if (quad & 1) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    r = 172271;
    r = 5026995 - ((x2 * r) >> 30);
    r = 85569306 - ((x2 * r) >> 30);
    r = 693598672 - ((x2 * r) >> 30);
    r = 1686629714 - ((x2 * r) >> 30);
    s = (x * r) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 32767) s = 32767;
    return (quad >= 2) ? -int'(s) : int'(s);
  endfunction

  task automatic predict_reset();
    rate_r = 44100; tempo_r = 120; letter_r = 2; keydeg_r = 1; amp_r = 32767;
    phase_acc = 0; step_acc = 0; left_cnt = 0; rest_flag = 1;
  endtask

  // Apply one accepted transfer to the predictor.
  task automatic predict_item(input bit mode, input logic [23:0] d);
    longint unsigned deg, num, den, tp, rate, f, n, dv;
    int oct, k, e, sq;
    longint m;
    smp_t r;
    if (!mode) begin
      deg = d[2:0];
      oct = $signed(d[5:3]);
      num = d[13:6];
      den = d[21:14];
      tp = tempo_r;
      rate = rate_r;
      if (den == 0) den = 1;
      if (tp == 0) tp = 1;
      left_cnt = ((60 * rate * num) / (den * tp)) & 32'hFFFF_FFFF;
      if (deg == 0) begin
        rest_flag = 1; phase_acc = 0; step_acc = 0;
      end else begin
        k = scale_semis(deg) - scale_semis(keydeg_r);
        if (k < 0) begin
          k += 12; oct -= 1;
        end
        f = (letter_hz(letter_r) * semi_ratio(k)) >> 16;
        if (rate == 0) rate = 1;
        e = PB + oct - 16;
        if (e >= 0) begin
          n = f << e; dv = rate;
        end else begin
          n = f; dv = rate << (-e);
        end
        step_acc = (n / dv) & PMASK;
        rest_flag = 0;
      end
    end else if (left_cnt != 0) begin
      m = 0;
      if (!rest_flag) begin
        sq = sine_q15(phase_acc);
        m = longint'(((sq < 0 ? -sq : sq) * amp_r) >> 15);
        if (sq < 0) m = -m;
        phase_acc = (phase_acc + step_acc) & PMASK;
      end
      r.sample = m[15:0];
      r.last = (left_cnt == 1);
      left_cnt--;
      sample_q = {sample_q, r};
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    smp_t exp_s;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_samples++;
      if (sample_q.size() == 0) begin
        $display("%t unexpected sample %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        exp_s = sample_q.pop_front();
        if (exp_s.sample !== m_axis_tdata) begin
          $display("%t sample: expected %h actual %h", $time, exp_s.sample, m_axis_tdata);
          errors++;
        end
        if (exp_s.last !== m_axis_tlast) begin
          $display("%t last: expected %b actual %b", $time, exp_s.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  initial begin
    int run;
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk_i);
        hold_rx = 0;
      end
      run = $urandom_range(0, 3);
      if (run == 0) m_axis_tready <= 0;
      else m_axis_tready <= 1;
    end
  end

  // Send one item after the previous transfer and a random gap, aligned to a falling edge.
  task automatic send_item(input bit mode, input logic [23:0] d);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gap_max) : 0;
    repeat (gap + 1) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser <= mode;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(mode, d);
    n_items++;
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [23:0] note(input int deg, input int oct, input int num,
                                       input int den);
    logic [2:0] o;
    o = oct[2:0];
    return {2'b00, den[7:0], num[7:0], o, deg[2:0]};
  endfunction

  task automatic drain();
    while (sample_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      CFG_SAMPLE_RATE: rate_r = v;
      CFG_TEMPO:       tempo_r = v[9:0];
      CFG_KEY_LETTER:  letter_r = v[2:0];
      CFG_KEY_DEGREE:  keydeg_r = v[2:0];
      CFG_MAX_AMP:     amp_r = v[14:0];
      default: ;
    endcase
  endtask

  // Small sample counts: high tempo and short lengths.
  task automatic set_fast(input int rate, input int ltr, input int kd, input int amp);
    write_reg(CFG_SAMPLE_RATE, 18'(rate));
    write_reg(CFG_TEMPO, 18'd999);
    write_reg(CFG_KEY_LETTER, 18'(ltr));
    write_reg(CFG_KEY_DEGREE, 18'(kd));
    write_reg(CFG_MAX_AMP, 18'(amp));
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(1, 24'($urandom));
  endtask

  // Directed extremes: rest, highest note, a low note, zero numerator, idle ticks.
  task automatic test_directed();
    set_fast(8000, 0, 1, 32767);
    ticks(1);
    send_item(0, note(7, 3, 3, 1)); ticks(4);
    send_item(0, note(1, -3, 1, 1)); ticks(4);
    send_item(0, note(0, 0, 2, 1)); ticks(3);
    send_item(0, note(4, 1, 0, 1)); ticks(2);
    send_item(0, note(5, 0, 255, 128)); ticks(2);
    send_item(0, note(2, -1, 1, 0)); ticks(3);
    drain();
    set_fast(192000, 7, 0, 0);
    send_item(0, note(3, 2, 1, 2)); ticks(3);
    send_item(0, note(6, -2, 1, 1)); send_item(0, note(1, 0, 1, 1)); ticks(3);
    drain();
  endtask

  // Random phrases of loads, each followed by up to ten ticks.
  task automatic test_random(input int total);
    int deg, cnt;
    while (n_items < total) begin
      deg = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 7);
      send_item(0, note(deg, $urandom_range(0, 6) - 3, $urandom_range(0, 255),
                        1 << $urandom_range(0, 7)) ^ ($urandom_range(0, 9) == 0 ?
                        24'($urandom) & 24'h3FC000 : 24'h0));
      cnt = $urandom_range(0, 10);
      repeat (cnt) send_item(1, 24'($urandom));
    end
  endtask

  // Phases across register settings, with the pressure cases inside.
  task automatic test_settings();
    set_fast($urandom_range(8000, 192000), $urandom_range(0, 7), $urandom_range(0, 7),
             $urandom_range(0, 32767));
    test_random(n_items + 150);
    drain();
    set_fast(44100, 4, 7, 12345);
    write_reg(CFG_TEMPO, 18'd1);
    send_item(0, note(3, 0, 1, 128));
    hold_rx = 1;
    ticks(40);
    drain();
    write_reg(CFG_TEMPO, 18'd999);
    gap_max = 30;
    test_random(n_items + 150);
    drain();
    gap_max = 3;
    set_fast(8000, 1, 4, 32767);
    test_random(n_items + 200);
    drain();
    set_fast(192000, 6, 2, 1);
    gap_max = 0;
    test_random(n_items + 150);
  endtask

  initial begin
    predict_reset();
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_settings();
    drain();
    $display("Sent %0d note and tick transfers, checked %0d samples over several settings.",
             n_items, n_samples);
    if (errors == 0 && sample_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
